[hw/rtl/prefix_code_bit_decoder_core_assert.svh]
// Assertion macros for the prefix-code decoder RTL.
`ifndef PREFIX_CODE_BIT_DECODER_CORE_ASSERT_SVH
`define PREFIX_CODE_BIT_DECODER_CORE_ASSERT_SVH

`ifndef SYNTHESIS
`define PDC_ASSERT_IMP(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");
`define PDC_ASSERT_NXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");
`else
`define PDC_ASSERT_IMP(name, clk, rst_n, ante, cons)
`define PDC_ASSERT_NXT(name, clk, rst_n, ante, cons)
`endif

`endif

[hw/rtl/pdc_pkg.sv]
// Types and constants of the prefix-code decoder.
package pdc_pkg;

    localparam int ACC_W  = 32;
    localparam int LEN_W  = 6;
    localparam int SYM_W  = 8;
    localparam int BYTE_W = 8;
    localparam int VB_W   = 4;
    localparam int GRP_W  = 16;
    localparam int GIDX_W = 4;

    localparam logic OP_LOAD       = 1'b0;
    localparam logic OP_DECODE     = 1'b1;
    localparam logic KIND_SYMBOL   = 1'b0;
    localparam logic KIND_OVERFLOW = 1'b1;

    typedef struct packed {
        logic              operation;
        logic [SYM_W-1:0]  symbol;
        logic [ACC_W-1:0]  code_bits;
        logic [LEN_W-1:0]  code_length;
        logic [BYTE_W-1:0] data_byte;
        logic [VB_W-1:0]   valid_bits;
    } t_in_item;

    typedef struct packed {
        logic [SYM_W-1:0] symbol_res;
        logic             kind;
        logic             last;
    } t_out_item;

    typedef struct packed {
        logic [ACC_W-1:0] acc;
        logic [ACC_W-1:0] mask;
        logic [LEN_W-1:0] len_tgt;
        logic             tgt_ok;
    } t_probe;

    typedef struct packed {
        logic              any;
        logic [GIDX_W-1:0] idx;
    } t_grp_hit;

endpackage

[hw/rtl/pdc_cell.sv]
// One code table entry with its registered match against the accumulator.
module pdc_cell (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_we,
    input  logic [pdc_pkg::ACC_W-1:0]   i_code,
    input  logic [pdc_pkg::LEN_W-1:0]   i_len,
    input  pdc_pkg::t_probe             i_probe,
    output logic                        o_hit
);

    logic [pdc_pkg::ACC_W-1:0] r_code;
    logic [pdc_pkg::LEN_W-1:0] r_len;
    logic                      r_hit;
    logic                      n_hit;

    assign n_hit = i_probe.tgt_ok && (r_len != '0) && (r_len == i_probe.len_tgt) &&
                   (((r_code ^ i_probe.acc) & i_probe.mask) == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= '0;
            r_hit <= 1'b0;
        end else begin
            if (i_we) begin
                r_len <= i_len;
            end
            r_hit <= n_hit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_code <= i_code;
        end
    end

    assign o_hit = r_hit;

endmodule

[hw/rtl/pdc_group.sv]
// Registered highest-index priority pick over one group of cell matches.
module pdc_group (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic [pdc_pkg::GRP_W-1:0] i_hits,
    output pdc_pkg::t_grp_hit         o_grp
);

    pdc_pkg::t_grp_hit r_grp;
    pdc_pkg::t_grp_hit n_grp;

    always_comb begin
        n_grp.any = |i_hits;
        n_grp.idx = '0;
        for (int i = 0; i < pdc_pkg::GRP_W; i++) begin
            if (i_hits[i]) begin
                n_grp.idx = pdc_pkg::GIDX_W'(i);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grp <= '0;
        end else begin
            r_grp <= n_grp;
        end
    end

    assign o_grp = r_grp;

endmodule

[hw/rtl/prefix_code_bit_decoder_core.sv]
// Load item: writes one table entry, no result. Decode item of n bits: each bit in turn goes
// through the accumulator shift, the registered match in the row of table cells and the
// registered group pick; a full output register stalls the decode until it drains.
// Hold each result as pending until the next one or the flush cycle; it then goes to the registered output.
// Synchronous active-low reset empties the table lengths, accumulator and output.
`include "prefix_code_bit_decoder_core_assert.svh"
module prefix_code_bit_decoder_core #(
    parameter int MAX_CODE_LEN = 32,
    parameter int SYMBOL_COUNT = 256
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  pdc_pkg::t_in_item   i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output pdc_pkg::t_out_item  o_out_data
);

    localparam int NG    = (SYMBOL_COUNT + pdc_pkg::GRP_W - 1) / pdc_pkg::GRP_W;
    localparam int CNT_W = $clog2(MAX_CODE_LEN + 1);
    localparam int EXT_W = (CNT_W > pdc_pkg::LEN_W) ? CNT_W : pdc_pkg::LEN_W;
    localparam int AW    = pdc_pkg::ACC_W;
    localparam int SW    = pdc_pkg::SYM_W;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SHIFT = 3'd1;
    localparam logic [2:0] S_HIT   = 3'd2;
    localparam logic [2:0] S_GRP   = 3'd3;
    localparam logic [2:0] S_RES   = 3'd4;
    localparam logic [2:0] S_FLUSH = 3'd5;

    logic [2:0]        r_state,      n_state;
    logic [AW-1:0]     r_acc,        n_acc;
    logic [AW-1:0]     r_mask,       n_mask;
    logic [CNT_W-1:0]  r_count,      n_count;
    logic [7:0]        r_byte,       n_byte;
    logic [2:0]        r_idx,        n_idx;
    logic              r_pend_valid, n_pend_valid;
    logic [SW-1:0]     r_pend_sym,   n_pend_sym;
    logic              r_pend_kind,  n_pend_kind;
    logic              r_out_valid;
    pdc_pkg::t_out_item r_out;

    logic              w_in_xfer;
    logic              w_out_free;
    logic              w_push;
    pdc_pkg::t_out_item w_push_item;
    logic              w_any;
    logic              w_ovf;
    logic              w_event;
    logic [SW-1:0]     w_sym;
    logic [2:0]        w_last_idx;
    logic [2:0]        w_nidx;
    logic [AW-1:0]     w_base_acc;
    logic [AW-1:0]     w_base_mask;
    logic [CNT_W-1:0]  w_base_count;
    logic [EXT_W-1:0]  w_count_ext;
    pdc_pkg::t_probe   w_probe;
    logic [NG*pdc_pkg::GRP_W-1:0] w_hits;
    pdc_pkg::t_grp_hit w_grp [NG];

    assign o_in_stall = (r_state != S_IDLE);
    assign w_in_xfer  = i_in_valid && !o_in_stall;
    assign w_out_free = !r_out_valid || !i_out_stall;

    assign w_count_ext     = EXT_W'(r_count);
    assign w_probe.acc     = r_acc;
    assign w_probe.mask    = r_mask;
    assign w_probe.len_tgt = w_count_ext[pdc_pkg::LEN_W-1:0];
    assign w_probe.tgt_ok  = (w_count_ext <= EXT_W'(pdc_pkg::ACC_W));

    for (genvar s = 0; s < NG * pdc_pkg::GRP_W; s++) begin : g_cell
        if (s < SYMBOL_COUNT) begin : g_used
            pdc_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_we    (w_in_xfer && (i_in_data.operation == pdc_pkg::OP_LOAD) &&
                          (i_in_data.symbol == SW'(s))),
                .i_code  (i_in_data.code_bits),
                .i_len   (i_in_data.code_length),
                .i_probe (w_probe),
                .o_hit   (w_hits[s])
            );
        end else begin : g_pad
            assign w_hits[s] = 1'b0;
        end
    end

    for (genvar g = 0; g < NG; g++) begin : g_grp
        pdc_group u_group (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_hits  (w_hits[g*pdc_pkg::GRP_W +: pdc_pkg::GRP_W]),
            .o_grp   (w_grp[g])
        );
    end

    always_comb begin
        w_any = 1'b0;
        w_sym = '0;
        for (int g = 0; g < NG; g++) begin
            if (w_grp[g].any) begin
                w_any = 1'b1;
                w_sym = SW'(g * pdc_pkg::GRP_W) | SW'(w_grp[g].idx);
            end
        end
    end

    assign w_ovf   = !w_any && (r_count >= CNT_W'(MAX_CODE_LEN));
    assign w_event = w_any || w_ovf;

    assign w_last_idx = ((i_in_data.valid_bits == '0) ||
                         (i_in_data.valid_bits > pdc_pkg::VB_W'(pdc_pkg::BYTE_W))) ?
                        3'd7 : 3'(i_in_data.valid_bits - pdc_pkg::VB_W'(1));
    assign w_nidx       = r_idx - 3'd1;
    assign w_base_acc   = w_event ? '0 : r_acc;
    assign w_base_mask  = w_event ? '0 : r_mask;
    assign w_base_count = w_event ? '0 : r_count;

    always_comb begin
        n_state      = r_state;
        n_acc        = r_acc;
        n_mask       = r_mask;
        n_count      = r_count;
        n_byte       = r_byte;
        n_idx        = r_idx;
        n_pend_valid = r_pend_valid;
        n_pend_sym   = r_pend_sym;
        n_pend_kind  = r_pend_kind;
        w_push       = 1'b0;
        w_push_item  = '0;
        case (r_state)
            S_IDLE: begin
                if (w_in_xfer) begin
                    if (i_in_data.operation == pdc_pkg::OP_LOAD) begin
                        n_acc   = '0;
                        n_mask  = '0;
                        n_count = '0;
                    end else begin
                        n_byte  = i_in_data.data_byte;
                        n_idx   = w_last_idx;
                        n_state = S_SHIFT;
                    end
                end
            end
            S_SHIFT: begin
                n_acc   = {r_acc[AW-2:0], r_byte[r_idx]};
                n_mask  = {r_mask[AW-2:0], 1'b1};
                n_count = r_count + CNT_W'(1);
                n_state = S_HIT;
            end
            S_HIT: begin
                n_state = S_GRP;
            end
            S_GRP: begin
                n_state = S_RES;
            end
            S_RES: begin
                if (!(w_event && r_pend_valid && !w_out_free)) begin
                    if (w_event) begin
                        if (r_pend_valid) begin
                            w_push                 = 1'b1;
                            w_push_item.symbol_res = r_pend_sym;
                            w_push_item.kind       = r_pend_kind;
                            w_push_item.last       = 1'b0;
                        end
                        n_pend_valid = 1'b1;
                        n_pend_sym   = w_any ? w_sym : '0;
                        n_pend_kind  = w_any ? pdc_pkg::KIND_SYMBOL : pdc_pkg::KIND_OVERFLOW;
                    end
                    if (r_idx != 3'd0) begin
                        n_idx   = w_nidx;
                        n_acc   = {w_base_acc[AW-2:0], r_byte[w_nidx]};
                        n_mask  = {w_base_mask[AW-2:0], 1'b1};
                        n_count = w_base_count + CNT_W'(1);
                        n_state = S_HIT;
                    end else begin
                        n_acc   = w_base_acc;
                        n_mask  = w_base_mask;
                        n_count = w_base_count;
                        n_state = S_FLUSH;
                    end
                end
            end
            S_FLUSH: begin
                if (r_pend_valid) begin
                    if (w_out_free) begin
                        w_push                 = 1'b1;
                        w_push_item.symbol_res = r_pend_sym;
                        w_push_item.kind       = r_pend_kind;
                        w_push_item.last       = 1'b1;
                        n_pend_valid           = 1'b0;
                        n_state                = S_IDLE;
                    end
                end else begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_acc        <= '0;
            r_mask       <= '0;
            r_count      <= '0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_acc        <= n_acc;
            r_mask       <= n_mask;
            r_count      <= n_count;
            r_pend_valid <= n_pend_valid;
            if (w_push) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_byte      <= n_byte;
        r_idx       <= n_idx;
        r_pend_sym  <= n_pend_sym;
        r_pend_kind <= n_pend_kind;
        if (w_push) begin
            r_out <= w_push_item;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    `PDC_ASSERT_IMP(a_count_range, i_clk, i_rst_n, 1'b1, r_count <= CNT_W'(MAX_CODE_LEN))
    `PDC_ASSERT_IMP(a_mask_empty, i_clk, i_rst_n, r_count == '0, r_mask == '0)
    `PDC_ASSERT_IMP(a_idle_no_pend, i_clk, i_rst_n, r_state == S_IDLE, !r_pend_valid)
    `PDC_ASSERT_IMP(a_last_flush, i_clk, i_rst_n, w_push && w_push_item.last, r_state == S_FLUSH)
    `PDC_ASSERT_NXT(a_push_shows, i_clk, i_rst_n, w_push, o_out_valid)

endmodule

[test/prefix_code_bit_decoder_core_tb.sv]
// Self-checking testbench for the prefix-code bit decoder core: table loads, bit decode, overflow.
module prefix_code_bit_decoder_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_CODE_LEN = 32;
    localparam int SYMBOL_COUNT = 256;
    localparam int RAND_ITEMS   = 300;
    localparam int HOLD_CYCLES  = 300;
    localparam int QUIET_LIMIT  = 3000;
    localparam int TAIL_CYCLES  = 100;

    class decode_scoreboard;
        bit [pdc_pkg::ACC_W-1:0] code_mem [SYMBOL_COUNT];
        bit [pdc_pkg::LEN_W-1:0] len_mem [SYMBOL_COUNT];
        bit [pdc_pkg::ACC_W-1:0] shift_acc;
        int unsigned             shift_cnt;
        pdc_pkg::t_out_item      pending_symbols [$];
        int                      errors;
        int                      n_symbols;
        int                      n_overflows;

        function int find_code();
            bit [pdc_pkg::ACC_W-1:0] mask;
            for (int s = SYMBOL_COUNT - 1; s >= 0; s--) begin
                if (len_mem[s] == 0 || len_mem[s] > MAX_CODE_LEN || len_mem[s] != shift_cnt)
                    continue;
                mask = (len_mem[s] == pdc_pkg::ACC_W) ? '1 :
                       ((32'd1 << len_mem[s]) - 32'd1);
                if ((code_mem[s] & mask) == (shift_acc & mask)) return s;
            end
            return -1;
        endfunction

        function void predict_symbols(pdc_pkg::t_in_item item);
            int                 nbits;
            int                 hit;
            bit                 held_ok;
            pdc_pkg::t_out_item held;
            pdc_pkg::t_out_item found;
            if (item.operation == pdc_pkg::OP_LOAD) begin
                code_mem[item.symbol] = item.code_bits;
                len_mem[item.symbol]  = item.code_length;
                shift_acc = '0;
                shift_cnt = 0;
                return;
            end
            nbits = item.valid_bits;
            if (nbits == 0 || nbits > pdc_pkg::BYTE_W) nbits = pdc_pkg::BYTE_W;
            held_ok = 1'b0;
            held    = '0;
            for (int b = nbits - 1; b >= 0; b--) begin
                shift_acc = {shift_acc[pdc_pkg::ACC_W-2:0], item.data_byte[b]};
                shift_cnt++;
                hit   = find_code();
                found = '0;
                if (hit >= 0) begin
                    found.symbol_res = hit[pdc_pkg::SYM_W-1:0];
                    found.kind       = pdc_pkg::KIND_SYMBOL;
                end else if (shift_cnt >= MAX_CODE_LEN) begin
                    found.kind = pdc_pkg::KIND_OVERFLOW;
                end else begin
                    continue;
                end
                if (held_ok) pending_symbols.push_back(held);
                held      = found;
                held_ok   = 1'b1;
                shift_acc = '0;
                shift_cnt = 0;
            end
            if (held_ok) begin
                held.last = 1'b1;
                pending_symbols.push_back(held);
            end
        endfunction

        task report_mismatch(string msg);
            $display("MISMATCH at %0t: %s", $realtime, msg);
            errors++;
        endtask

        task check_symbol(pdc_pkg::t_out_item got);
            pdc_pkg::t_out_item want;
            if (pending_symbols.size() == 0) begin
                report_mismatch($sformatf("result with nothing expected: symbol %0d kind %0d last %0d",
                                          got.symbol_res, got.kind, got.last));
                return;
            end
            want = pending_symbols.pop_front();
            if (got.symbol_res !== want.symbol_res || got.kind !== want.kind ||
                got.last !== want.last) begin
                report_mismatch($sformatf("symbol %0d kind %0d last %0d, wanted %0d %0d %0d",
                                          got.symbol_res, got.kind, got.last,
                                          want.symbol_res, want.kind, want.last));
            end else if (got.kind == pdc_pkg::KIND_OVERFLOW) begin
                n_overflows++;
            end else begin
                n_symbols++;
            end
        endtask

        task finish_check();
            if (pending_symbols.size() != 0)
                report_mismatch($sformatf("%0d expected results never arrived",
                                          pending_symbols.size()));
        endtask
    endclass

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               in_valid  = 1'b0;
    logic               in_stall;
    pdc_pkg::t_in_item  in_data   = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    pdc_pkg::t_out_item out_data;
    bit                 steady    = 1'b0;
    int                 n_sent    = 0;
    int                 n_loads   = 0;
    int                 n_holds   = 0;
    int                 n_drains  = 0;
    int                 live_syms [$];
    decode_scoreboard   board = new();

    prefix_code_bit_decoder_core u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data)
    );

    always #10 clk = ~clk;

    function automatic pdc_pkg::t_in_item load_item(input int sym,
                                                    input logic [pdc_pkg::ACC_W-1:0] code,
                                                    input int len);
        pdc_pkg::t_in_item item;
        logic [31:0]       r;
        r = $urandom();
        item.operation   = pdc_pkg::OP_LOAD;
        item.symbol      = sym[pdc_pkg::SYM_W-1:0];
        item.code_bits   = code;
        item.code_length = len[pdc_pkg::LEN_W-1:0];
        item.data_byte   = r[7:0];
        item.valid_bits  = r[11:8];
        return item;
    endfunction

    function automatic pdc_pkg::t_in_item decode_item(input logic [31:0] data_v, input int vb);
        pdc_pkg::t_in_item item;
        logic [31:0]       r;
        r = $urandom();
        item.operation   = pdc_pkg::OP_DECODE;
        item.symbol      = r[7:0];
        item.code_bits   = $urandom();
        item.code_length = r[13:8];
        item.data_byte   = data_v[7:0];
        item.valid_bits  = vb[pdc_pkg::VB_W-1:0];
        return item;
    endfunction

    function automatic int rand_vb();
        return ($urandom_range(4) == 0) ? $urandom_range(15) : pdc_pkg::BYTE_W;
    endfunction

    task automatic send_item(input pdc_pkg::t_in_item item);
        while (!steady && $urandom_range(99) < 38) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        @(posedge clk);
        while (in_stall !== 1'b0) @(posedge clk);
        board.predict_symbols(item);
        n_sent++;
        if (item.operation == pdc_pkg::OP_LOAD) n_loads++;
    endtask

    task automatic pause_until_drained();
        in_valid <= 1'b0;
        do @(posedge clk); while (board.pending_symbols.size() != 0);
        n_drains++;
    endtask

    task automatic retire_live();
        int len;
        while (live_syms.size() != 0) begin
            len = ($urandom_range(3) == 0) ? $urandom_range(MAX_CODE_LEN + 1, 63) : 0;
            send_item(load_item(live_syms.pop_front(), $urandom(), len));
        end
    endtask

    task automatic run_directed();
        send_item(load_item(200, 32'hFFFF_FFFE, 1));
        send_item(load_item(3, 32'h0000_0000, 1));
        send_item(load_item(1, 32'hAAAA_AAAA, 2));
        send_item(load_item(2, 32'h0000_0003, 2));
        send_item(load_item(7, 32'hFFFF_FFFF, 0));
        send_item(load_item(9, 32'h0000_0001, 63));
        send_item(decode_item(32'h00, 8));
        send_item(decode_item(32'hB2, 0));
        send_item(decode_item(32'hFF, 3));
        send_item(decode_item(32'h7F, 15));
        send_item(load_item(255, 32'h0000_0000, 33));
        send_item(decode_item(32'hFE, 1));
        send_item(load_item(200, $urandom(), 0));
        send_item(load_item(3, $urandom(), 0));
        send_item(load_item(1, $urandom(), 0));
        send_item(load_item(2, $urandom(), 0));
        send_item(load_item(0, 32'hA5C3_0F96, 32));
        live_syms.push_back(0);
        send_item(decode_item(32'hA5, 8));
        send_item(decode_item(32'hC3, 8));
        send_item(decode_item(32'h0F, 8));
        send_item(decode_item(32'h96, 8));
        repeat (4) send_item(decode_item(32'h00, 8));
    endtask

    task automatic run_fixed_code();
        int          width;
        int          base;
        int          sym;
        logic [31:0] code;
        width = $urandom_range(1, 4);
        base  = $urandom_range(255);
        for (int c = 0; c < (1 << width); c++) begin
            sym  = (base + c) % SYMBOL_COUNT;
            code = ($urandom() << width) | c;
            send_item(load_item(sym, code, width));
            live_syms.push_back(sym);
        end
        repeat ($urandom_range(15, 30)) send_item(decode_item($urandom(), rand_vb()));
    endtask

    task automatic run_unary_code();
        int          depth;
        int          sym;
        logic [31:0] code;
        depth = $urandom_range(2, 6);
        for (int k = 1; k <= depth; k++) begin
            sym  = $urandom_range(255);
            code = ($urandom() << k) | (((32'd1 << (k - 1)) - 32'd1) << 1);
            send_item(load_item(sym, code, k));
            live_syms.push_back(sym);
        end
        repeat ($urandom_range(12, 25)) begin
            if ($urandom_range(4) == 0)
                repeat (5) send_item(decode_item(32'hFF, pdc_pkg::BYTE_W));
            else
                send_item(decode_item($urandom(), rand_vb()));
        end
    endtask

    task automatic run_long_code();
        int          len;
        int          sym;
        int          head;
        logic [31:0] code;
        logic [31:0] part;
        len  = $urandom_range(9, MAX_CODE_LEN);
        sym  = $urandom_range(255);
        code = $urandom();
        send_item(load_item(sym, code, len));
        live_syms.push_back(sym);
        head = len % pdc_pkg::BYTE_W;
        repeat ($urandom_range(3, 5)) begin
            if (head != 0) begin
                part = ((code >> (len - head)) & ((32'd1 << head) - 32'd1)) |
                       ($urandom() << head);
                send_item(decode_item(part, head));
            end
            for (int k = (len - head) / pdc_pkg::BYTE_W - 1; k >= 0; k--)
                send_item(decode_item(code >> (pdc_pkg::BYTE_W * k), pdc_pkg::BYTE_W));
        end
    endtask

    task automatic run_noise();
        int sym;
        int len;
        repeat ($urandom_range(10, 20)) begin
            if ($urandom_range(1) == 0) begin
                sym = $urandom_range(255);
                len = $urandom_range(63);
                send_item(load_item(sym, $urandom(), len));
                if (len != 0 && len <= MAX_CODE_LEN) live_syms.push_back(sym);
            end else begin
                send_item(decode_item($urandom(), $urandom_range(15)));
            end
        end
    endtask

    initial begin : stimulus
        int phase;
        int rand_start;
        phase = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        run_directed();
        pause_until_drained();
        rand_start = n_sent;
        while (n_sent < rand_start + RAND_ITEMS) begin
            phase++;
            steady = (phase >= 4 && phase <= 6);
            retire_live();
            case ($urandom_range(9))
                0, 1, 2, 3: run_fixed_code();
                4, 5, 6:    run_unary_code();
                7, 8:       run_long_code();
                default:    run_noise();
            endcase
            if (phase % 4 == 0) pause_until_drained();
        end
        steady = 1'b0;
        pause_until_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        board.finish_check();
        $display("run covered %0d items (%0d table loads) with %0d symbols and %0d overflows",
                 n_sent, n_loads, board.n_symbols, board.n_overflows);
        $display("run included %0d receiver hold-offs and %0d sender drain pauses",
                 n_holds, n_drains);
        if (board.errors == 0) begin
            $display("prefix_code_bit_decoder_core_tb: clean");
        end else begin
            $display("prefix_code_bit_decoder_core_tb: errors");
        end
        $finish;
    end

    initial begin : receiver
        int hold_left;
        int seen;
        int next_hold;
        hold_left = 0;
        seen      = 0;
        next_hold = 60;
        forever begin
            @(posedge clk);
            if (out_valid === 1'b1 && out_stall == 1'b0) begin
                board.check_symbol(out_data);
                seen++;
            end
            if (hold_left > 0) begin
                hold_left--;
            end else if (seen >= next_hold) begin
                hold_left = HOLD_CYCLES;
                next_hold = seen + 250;
                n_holds++;
            end
            out_stall <= (hold_left > 0) || (!steady && $urandom_range(99) < 38);
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge clk);
            if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall))
                quiet = 0;
            else
                quiet++;
        end
        $display("prefix_code_bit_decoder_core_tb: errors");
        $finish;
    end

endmodule

[sim.f]
+incdir+hw/rtl
hw/rtl/pdc_pkg.sv
hw/rtl/pdc_cell.sv
hw/rtl/pdc_group.sv
hw/rtl/prefix_code_bit_decoder_core.sv
test/prefix_code_bit_decoder_core_tb.sv
